// ===== sv/julia_escape_time_pixel_top_defines.svh =====
// Assertion macros of the Julia escape-time pixel unit, used by its controller.
`ifndef JULIA_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define JETP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define JETP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jetp_pkg.sv =====
// Package with types, constants and the color function of the Julia pixel unit.
package jetp_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned ITER_BITS  = 12;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned COLOR_W    = 24;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_RE_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IM_START   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RE_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IM_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd6;

  // Register values after reset.
  localparam logic signed [CFG_W-1:0] RST_RE_START = -32'sd402653184;
  localparam logic signed [CFG_W-1:0] RST_IM_START = -32'sd268435456;
  localparam logic signed [CFG_W-1:0] RST_RE_STEP  = 32'sd1258291;
  localparam logic signed [CFG_W-1:0] RST_IM_STEP  = 32'sd1118481;
  localparam logic signed [CFG_W-1:0] RST_C_REAL   = -32'sd187904819;
  localparam logic signed [CFG_W-1:0] RST_C_IMAG   = 32'sd72517838;
  localparam logic [ITER_BITS-1:0]    RST_LIMIT    = 12'd300;

  // Hue sector width of the six-sector rule.
  localparam logic [7:0] SECTOR = 8'd43;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } in_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_column;
    logic [COORD_BITS-1:0] pixel_row;
    logic [ITER_BITS-1:0]  iterations;
    logic                  escaped;
    logic [COLOR_W-1:0]    color;
  } out_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 cap_in;
    logic                 init_mul;
    logic                 init_add;
    logic                 iter_mul;
    logic                 z_load;
    logic                 out_load;
    logic [ITER_BITS-1:0] iterations;
    logic                 escaped;
  } jetp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mag_over;
    logic bound_over;
  } jetp_sts_t;

  // Full-saturation, full-value color for one hue.
  function automatic logic [COLOR_W-1:0] hue_color(input logic [7:0] h);
    logic [2:0]  region;
    logic [7:0]  base;
    logic [7:0]  rem;
    logic [15:0] sq;
    logic [15:0] st;
    logic [15:0] qw;
    logic [15:0] tw;
    logic [7:0]  q;
    logic [7:0]  t;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    if (h >= 8'd215) begin
      region = 3'd5;
    end else if (h >= 8'd172) begin
      region = 3'd4;
    end else if (h >= 8'd129) begin
      region = 3'd3;
    end else if (h >= 8'd86) begin
      region = 3'd2;
    end else if (h >= SECTOR) begin
      region = 3'd1;
    end else begin
      region = 3'd0;
    end
    base = 8'({5'd0, region} * SECTOR);
    rem  = 8'((h - base) * 8'd6);
    sq   = 16'd255 * {8'd0, rem};
    st   = 16'd255 * {8'd0, 8'd255 - rem};
    qw   = 16'd255 * {8'd0, 8'd255 - sq[15:8]};
    tw   = 16'd255 * {8'd0, 8'd255 - st[15:8]};
    q    = qw[15:8];
    t    = tw[15:8];
    unique case (region)
      3'd0: begin r = 8'd255; g = t;      b = 8'd0;   end
      3'd1: begin r = q;      g = 8'd255; b = 8'd0;   end
      3'd2: begin r = 8'd0;   g = 8'd255; b = t;      end
      3'd3: begin r = 8'd0;   g = q;      b = 8'd255; end
      3'd4: begin r = t;      g = 8'd0;   b = 8'd255; end
      default: begin r = 8'd255; g = 8'd0; b = q;     end
    endcase
    return {r, g, b};
  endfunction

endpackage

// ===== sv/jetp_ctrl.sv =====
// Controller state machine of the Julia pixel unit: sequencing, counts and handshakes.
`include "julia_escape_time_pixel_top_defines.svh"

module jetp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [jetp_pkg::ITER_BITS-1:0] limit_i,
  input  jetp_pkg::jetp_sts_t           sts_i,
  output jetp_pkg::jetp_cmd_t           cmd_o
);
  import jetp_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INIT_MUL = 3'd1;
  localparam logic [2:0] S_INIT_ADD = 3'd2;
  localparam logic [2:0] S_ITER_MUL = 3'd3;
  localparam logic [2:0] S_ITER_ADD = 3'd4;
  localparam logic [2:0] S_WRITE    = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [ITER_BITS-1:0] cnt_q, cnt_d;
  logic [ITER_BITS-1:0] idx;
  logic                 esc_q, esc_d;
  logic                 pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Index of the iteration about to run in the add step.
  assign idx = pend_q ? cnt_q + 1'b1 : '0;

  // Next-state and command logic.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    esc_d   = esc_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    cmd_o.iterations = cnt_q;
    cmd_o.escaped    = esc_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          pend_d  = 1'b0;
          state_d = S_INIT_MUL;
        end
      end
      S_INIT_MUL: begin
        cmd_o.init_mul = 1'b1;
        state_d = S_INIT_ADD;
      end
      S_INIT_ADD: begin
        cmd_o.init_add = 1'b1;
        if (limit_i == '0) begin
          cnt_d   = '0;
          esc_d   = 1'b0;
          state_d = S_WRITE;
        end else begin
          state_d = S_ITER_MUL;
        end
      end
      S_ITER_MUL: begin
        cmd_o.iter_mul = 1'b1;
        state_d = S_ITER_ADD;
      end
      S_ITER_ADD: begin
        // The magnitude test of the last point comes first, then the limit.
        priority if (pend_q && sts_i.mag_over) begin
          esc_d   = 1'b1;
          state_d = S_WRITE;
        end else if (pend_q && idx == limit_i) begin
          cnt_d   = limit_i;
          esc_d   = 1'b0;
          state_d = S_WRITE;
        end else if (sts_i.bound_over) begin
          cnt_d   = idx;
          esc_d   = 1'b1;
          state_d = S_WRITE;
        end else begin
          cmd_o.z_load = 1'b1;
          cnt_d   = idx;
          pend_d  = 1'b1;
          state_d = S_ITER_MUL;
        end
      end
      S_WRITE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid follows loads and taken results.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      esc_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      esc_q       <= esc_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  `JETP_ASSERT_SAME(a_final_count, clk_i, rst_ni, state_q == S_WRITE,
    esc_q ? (cnt_q < limit_i) : (cnt_q == limit_i), "final count disagrees with escape flag")
  `JETP_ASSERT_SAME(a_loop_count, clk_i, rst_ni, state_q == S_ITER_MUL && pend_q,
    cnt_q < limit_i, "iteration count reached the limit inside the loop")
  `JETP_ASSERT_NEXT(a_mul_then_add, clk_i, rst_ni, state_q == S_ITER_MUL,
    state_q == S_ITER_ADD, "product step not followed by the add step")
  `JETP_ASSERT_NEXT(a_write_waits, clk_i, rst_ni,
    state_q == S_WRITE && out_valid_q && out_stall_i,
    state_q == S_WRITE && out_valid_q, "result overwrote a stalled result")

endmodule

// ===== sv/jetp_dp.sv =====
// Datapath of the Julia pixel unit: start point, complex square-and-add, escape tests, result.
module jetp_dp #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                               clk_i,
  input  jetp_pkg::jetp_cmd_t                cmd_i,
  output jetp_pkg::jetp_sts_t                sts_o,
  input  jetp_pkg::in_req_t                  in_req_i,
  input  logic signed [jetp_pkg::CFG_W-1:0]  re_start_i,
  input  logic signed [jetp_pkg::CFG_W-1:0]  im_start_i,
  input  logic signed [jetp_pkg::CFG_W-1:0]  re_step_i,
  input  logic signed [jetp_pkg::CFG_W-1:0]  im_step_i,
  input  logic signed [jetp_pkg::CFG_W-1:0]  c_real_i,
  input  logic signed [jetp_pkg::CFG_W-1:0]  c_imag_i,
  output jetp_pkg::out_res_t                 out_res_o
);
  import jetp_pkg::*;

  // A point that keeps iterating lies within [-2, 2], which needs FRAC_BITS + 3 bits.
  localparam int unsigned ZW = (FRAC_BITS + 3 > CFG_W) ? FRAC_BITS + 3 : CFG_W;
  localparam int unsigned PW = 2 * ZW;
  localparam int unsigned SW = COORD_BITS + CFG_W;
  localparam logic signed [PW-1:0] BOUND =
    {{(PW - FRAC_BITS - 2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};
  localparam logic signed [PW-1:0] FOUR =
    {{(PW - FRAC_BITS - 3){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

  in_req_t               req_q;
  logic [CFG_W-1:0]      off_re_q, off_im_q;
  logic [SW-1:0]         off_re_full, off_im_full;
  logic signed [CFG_W-1:0] start_re, start_im;
  logic signed [ZW-1:0]  z_re_q, z_im_q;
  logic signed [PW-1:0]  pp_rr_q, pp_ii_q, pp_ri_q;
  logic signed [PW-1:0]  sq_rr, sq_ii, x_ri;
  logic signed [PW-1:0]  n_re, n_im, mag;
  out_res_t              out_q;

  // Offsets of the start point from the pixel indexes, wrapping at 32 bits.
  assign off_re_full = SW'(req_q.column) * SW'($unsigned(re_step_i));
  assign off_im_full = SW'(req_q.row) * SW'($unsigned(im_step_i));
  assign start_re    = re_start_i + signed'(off_re_q);
  assign start_im    = im_start_i + signed'(off_im_q);

  // Truncated products and the next point.
  assign sq_rr = pp_rr_q >>> FRAC_BITS;
  assign sq_ii = pp_ii_q >>> FRAC_BITS;
  assign x_ri  = pp_ri_q >>> (FRAC_BITS - 1);
  assign n_re  = sq_rr - sq_ii + PW'(c_real_i);
  assign n_im  = x_ri + PW'(c_imag_i);
  assign mag   = sq_rr + sq_ii;

  // Escape tests: squared magnitude of the current point, bound of the next one.
  assign sts_o.mag_over   = (mag > FOUR);
  assign sts_o.bound_over = (n_re > BOUND) || (n_re < -BOUND) ||
                            (n_im > BOUND) || (n_im < -BOUND);

  assign out_res_o = out_q;

  // Input capture and start point.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      req_q <= in_req_i;
    end
    if (cmd_i.init_mul) begin
      off_re_q <= off_re_full[CFG_W-1:0];
      off_im_q <= off_im_full[CFG_W-1:0];
    end
  end

  // Point register and product registers of the iteration.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_add) begin
      z_re_q <= ZW'(start_re);
      z_im_q <= ZW'(start_im);
    end else if (cmd_i.z_load) begin
      z_re_q <= signed'(n_re[ZW-1:0]);
      z_im_q <= signed'(n_im[ZW-1:0]);
    end
    if (cmd_i.iter_mul) begin
      pp_rr_q <= PW'(z_re_q) * PW'(z_re_q);
      pp_ii_q <= PW'(z_im_q) * PW'(z_im_q);
      pp_ri_q <= PW'(z_re_q) * PW'(z_im_q);
    end
  end

  // Result register with the color of the count, black for a point that did not escape.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.pixel_column <= req_q.column;
      out_q.pixel_row    <= req_q.row;
      out_q.iterations   <= cmd_i.iterations;
      out_q.escaped      <= cmd_i.escaped;
      out_q.color        <= cmd_i.escaped ? hue_color(cmd_i.iterations[7:0]) : '0;
    end
  end

endmodule

// ===== sv/julia_escape_time_pixel_top.sv =====
// Top level of the Julia escape-time pixel unit: configuration registers, controller, datapath.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    in_req_i (column, row)
//   out       output     out_valid_o / out_stall_i  out_res_o (coordinates, count, flag, color)
//   cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// From acceptance, a request runs a product state and an add state for its start point, then
// alternates a product state of the three multipliers and an add state per iteration, and ends
// in the write state that loads the result; a limit of zero goes straight to the write state.
// Requests are handled one at a time; a new request is taken while a result waits.
// Reset loads the default registers and leaves no result pending.
// A stalled result holds the finished request in its write step until the output frees.
module julia_escape_time_pixel_top #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  jetp_pkg::in_req_t                    in_req_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output jetp_pkg::out_res_t                   out_res_o,
  input  logic                                 cfg_we_i,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [jetp_pkg::CFG_W-1:0]           cfg_data_i
);
  import jetp_pkg::*;

  logic signed [CFG_W-1:0] re_start_q, im_start_q, re_step_q, im_step_q;
  logic signed [CFG_W-1:0] c_real_q, c_imag_q;
  logic [ITER_BITS-1:0]    limit_q;
  jetp_cmd_t               cmd;
  jetp_sts_t               sts;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_start_q <= RST_RE_START;
      im_start_q <= RST_IM_START;
      re_step_q  <= RST_RE_STEP;
      im_step_q  <= RST_IM_STEP;
      c_real_q   <= RST_C_REAL;
      c_imag_q   <= RST_C_IMAG;
      limit_q    <= RST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RE_START:   re_start_q <= signed'(cfg_data_i);
        REG_IM_START:   im_start_q <= signed'(cfg_data_i);
        REG_RE_STEP:    re_step_q  <= signed'(cfg_data_i);
        REG_IM_STEP:    im_step_q  <= signed'(cfg_data_i);
        REG_C_REAL:     c_real_q   <= signed'(cfg_data_i);
        REG_C_IMAG:     c_imag_q   <= signed'(cfg_data_i);
        REG_ITER_LIMIT: limit_q    <= cfg_data_i[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  jetp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .limit_i     (limit_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  jetp_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_req_i   (in_req_i),
    .re_start_i (re_start_q),
    .im_start_i (im_start_q),
    .re_step_i  (re_step_q),
    .im_step_i  (im_step_q),
    .c_real_i   (c_real_q),
    .c_imag_i   (c_imag_q),
    .out_res_o  (out_res_o)
  );

endmodule
